// ===== rtl/tsu_pkg.sv =====
// ----------------------------------------------------------------------------
// Timestamp-to-UTC package
// Shared types and constants for the timestamp text parser.
// ----------------------------------------------------------------------------
package tsu_pkg;

  localparam int unsigned StampLen = 14;
  localparam int unsigned SecW     = 39;

  // floor(x / 400) = (x * Recip400) >> 23 for any 14-bit x
  localparam logic [14:0] Recip400 = 15'd20972;

  localparam logic [1:0] ZoneNone    = 2'd0;
  localparam logic [1:0] ZoneApplied = 2'd1;
  localparam logic [1:0] ZoneIgnored = 2'd2;

  // Character classes reported by the datapath.
  typedef struct packed {
    logic ws;
    logic digit;
    logic sign;
    logic minus;
  } char_class_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       stamp_digit;   // feed stamp character
    logic [3:0] stamp_pos;
    logic       stamp_bad;     // mark non-digit
    logic       zone_sign;     // capture sign
    logic       zone_digit;    // feed zone digit
    logic [2:0] zone_pos;
    logic       clear;         // return to reset state
    logic       convert;       // start conversion
    logic [1:0] zone_kind;     // zone status for the result
    logic       phase_ok;      // reached rest phase or later
  } dp_cmd_t;

  typedef struct packed {
    logic busy;  // conversion or result held
  } dp_sts_t;

endpackage

// ===== rtl/timestamp_text_to_utc_seconds.sv =====
// ----------------------------------------------------------------------------
// Timestamp text to UTC seconds
// Parses a YYYYMMDDHHMMSS [+-HHMM] string one character per transaction.
// ----------------------------------------------------------------------------
// Input channel: one Latin-1 character per transaction, last_i on the final
// one. Characters are taken one per cycle while no conversion is pending.
// On the last character a conversion runs (range check, days-from-civil in
// steps, seconds multiply, zone offset); the result then sits in the output
// register until taken. The input stalls from the last character until the
// result has been taken. An output stall holds the result and keeps the
// input stalled. Reset returns the parser to the leading-space phase and
// drops any pending result.
// ----------------------------------------------------------------------------
module timestamp_text_to_utc_seconds import tsu_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             char_code_i,
  input  logic                   last_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   valid_res_o,
  output logic signed [SecW-1:0] utc_seconds_o,
  output logic [1:0]             zone_status_o
);

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  char_class_t cls;
  logic        take;

  assign in_stall_o = sts.busy;
  assign take       = in_valid_i && !in_stall_o;

  tsu_ctrl u_ctrl (
    .clk_i, .rst_ni, .take_i(take), .last_i, .cls_i(cls), .cmd_o(cmd)
  );

  tsu_dp u_dp (
    .clk_i, .rst_ni, .char_code_i, .cmd_i(cmd), .cls_o(cls), .sts_o(sts),
    .out_stall_i, .out_valid_o, .valid_res_o, .utc_seconds_o, .zone_status_o
  );

  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !take) else $error("input taken while result pending");
  a_convert_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.convert |-> (take && last_i)) else $error("convert without last");
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && last_i) |=> sts.busy) else $error("not busy after last");
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |-> (utc_seconds_o == '0))
    else $error("invalid result not zero");

endmodule

// ===== rtl/tsu_ctrl.sv =====
// ----------------------------------------------------------------------------
// Timestamp-to-UTC controller
// Parse state machine: leading space, stamp, rest, zone digits, tail, junk.
// ----------------------------------------------------------------------------
module tsu_ctrl import tsu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  logic        last_i,
  input  char_class_t cls_i,
  output dp_cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    PhLead, PhStamp, PhRest, PhZdig, PhZtail, PhJunk
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [3:0] cnt_q, cnt_d;
  logic [2:0] zcnt_q, zcnt_d;

  always_comb begin
    logic stamp;
    stamp   = 1'b0;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    zcnt_d  = zcnt_q;
    cmd_o   = '0;
    cmd_o.stamp_pos = cnt_q;
    cmd_o.zone_pos  = zcnt_q;
    case (phase_q)
      PhLead: begin
        if (!cls_i.ws) begin
          stamp = 1'b1;
        end
      end
      PhStamp: stamp = 1'b1;
      PhRest: begin
        if (cls_i.sign) begin
          cmd_o.zone_sign = take_i;
          phase_d = PhZdig;
        end else if (!cls_i.ws) begin
          phase_d = PhJunk;
        end
      end
      PhZdig: begin
        if (cls_i.digit) begin
          cmd_o.zone_digit = take_i;
          zcnt_d = zcnt_q + 3'd1;
          if (zcnt_q == 3'd3) begin
            phase_d = PhZtail;
          end
        end else begin
          phase_d = PhJunk;
        end
      end
      PhZtail: begin
        if (!cls_i.ws) begin
          phase_d = PhJunk;
        end
      end
      default: phase_d = PhJunk;
    endcase
    if (stamp) begin
      cmd_o.stamp_digit = take_i && cls_i.digit;
      cmd_o.stamp_bad   = take_i && !cls_i.digit;
      cnt_d   = cnt_q + 4'd1;
      phase_d = (cnt_q == 4'(StampLen - 1)) ? PhRest : PhStamp;
    end
    cmd_o.phase_ok = (phase_d == PhRest) || (phase_d == PhZdig) ||
                     (phase_d == PhZtail) || (phase_d == PhJunk);
    case (phase_d)
      PhZtail: cmd_o.zone_kind = ZoneApplied;
      PhRest:  cmd_o.zone_kind = ZoneNone;
      default: cmd_o.zone_kind = ZoneIgnored;
    endcase
    if (take_i && last_i) begin
      cmd_o.convert = 1'b1;
      cmd_o.clear   = 1'b1;
      phase_d = PhLead;
      cnt_d   = '0;
      zcnt_d  = '0;
    end else if (!take_i) begin
      phase_d = phase_q;
      cnt_d   = cnt_q;
      zcnt_d  = zcnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhLead;
      cnt_q   <= '0;
      zcnt_q  <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      zcnt_q  <= zcnt_d;
    end
  end

endmodule

// ===== rtl/tsu_dp.sv =====
// ----------------------------------------------------------------------------
// Timestamp-to-UTC datapath
// Field accumulators, date check and a multi-cycle seconds conversion.
// ----------------------------------------------------------------------------
module tsu_dp import tsu_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [7:0]             char_code_i,
  input  dp_cmd_t                cmd_i,
  output char_class_t            cls_o,
  output dp_sts_t                sts_o,
  input  logic                   out_stall_i,
  output logic                   out_valid_o,
  output logic                   valid_res_o,
  output logic signed [SecW-1:0] utc_seconds_o,
  output logic [1:0]             zone_status_o
);

  logic [13:0] year_q;
  logic [6:0]  month_q, day_q, hour_q, min_q, sec_q, zh_q, zm_q;
  logic        bad_q, zneg_q;
  logic [3:0]  v;

  assign v = char_code_i[3:0];
  assign cls_o.digit = (char_code_i >= 8'h30) && (char_code_i <= 8'h39);
  assign cls_o.ws    = ((char_code_i >= 8'h09) && (char_code_i <= 8'h0D)) ||
                       (char_code_i == 8'h20) || (char_code_i == 8'h85) ||
                       (char_code_i == 8'hA0);
  assign cls_o.sign  = (char_code_i == 8'h2B) || (char_code_i == 8'h2D);
  assign cls_o.minus = (char_code_i == 8'h2D);

  function automatic logic [6:0] acc7(logic [6:0] a, logic [3:0] d);
    logic [10:0] t;
    t = {4'd0, a} * 11'd10 + {7'd0, d};
    return t[6:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q <= '0; month_q <= '0; day_q <= '0; hour_q <= '0;
      min_q <= '0; sec_q <= '0; zh_q <= '0; zm_q <= '0;
      bad_q <= 1'b0; zneg_q <= 1'b0;
    end else if (cmd_i.clear) begin
      year_q <= '0; month_q <= '0; day_q <= '0; hour_q <= '0;
      min_q <= '0; sec_q <= '0; zh_q <= '0; zm_q <= '0;
      bad_q <= 1'b0; zneg_q <= 1'b0;
    end else begin
      if (cmd_i.stamp_bad) begin
        bad_q <= 1'b1;
      end
      if (cmd_i.stamp_digit) begin
        if (cmd_i.stamp_pos < 4'd4) begin
          year_q <= 14'(({4'd0, year_q} * 18'd10) + {14'd0, v});
        end else if (cmd_i.stamp_pos < 4'd6) begin
          month_q <= acc7(month_q, v);
        end else if (cmd_i.stamp_pos < 4'd8) begin
          day_q <= acc7(day_q, v);
        end else if (cmd_i.stamp_pos < 4'd10) begin
          hour_q <= acc7(hour_q, v);
        end else if (cmd_i.stamp_pos < 4'd12) begin
          min_q <= acc7(min_q, v);
        end else begin
          sec_q <= acc7(sec_q, v);
        end
      end
      if (cmd_i.zone_sign) begin
        zneg_q <= cls_o.minus;
      end
      if (cmd_i.zone_digit) begin
        if (cmd_i.zone_pos < 3'd2) begin
          zh_q <= acc7(zh_q, v);
        end else begin
          zm_q <= acc7(zm_q, v);
        end
      end
    end
  end

  // Snapshot of the final fields (including the last character's update).
  logic [13:0] y_n;
  logic [6:0]  mo_n, d_n, h_n, mi_n, s_n, zh_n, zm_n;
  logic        bad_n, zneg_n;

  always_comb begin
    y_n = year_q; mo_n = month_q; d_n = day_q; h_n = hour_q;
    mi_n = min_q; s_n = sec_q; zh_n = zh_q; zm_n = zm_q;
    bad_n = bad_q || cmd_i.stamp_bad;
    zneg_n = cmd_i.zone_sign ? cls_o.minus : zneg_q;
    if (cmd_i.stamp_digit) begin
      if (cmd_i.stamp_pos < 4'd4) begin
        y_n = 14'(({4'd0, year_q} * 18'd10) + {14'd0, v});
      end else if (cmd_i.stamp_pos < 4'd6) begin
        mo_n = acc7(month_q, v);
      end else if (cmd_i.stamp_pos < 4'd8) begin
        d_n = acc7(day_q, v);
      end else if (cmd_i.stamp_pos < 4'd10) begin
        h_n = acc7(hour_q, v);
      end else if (cmd_i.stamp_pos < 4'd12) begin
        mi_n = acc7(min_q, v);
      end else begin
        s_n = acc7(sec_q, v);
      end
    end
    if (cmd_i.zone_digit) begin
      if (cmd_i.zone_pos < 3'd2) begin
        zh_n = acc7(zh_q, v);
      end else begin
        zm_n = acc7(zm_q, v);
      end
    end
  end

  // Sequential conversion, one step per cycle.
  logic [3:0]  step_q;
  logic        run_q;
  logic [13:0] cy_q;
  logic [6:0]  cmo_q, cd_q, ch_q, cmi_q, cs_q, czh_q, czm_q;
  logic        cbad_q, cneg_q, cok_q;
  logic [1:0]  ckind_q;
  logic [13:0] yy_q;
  logic [3:0]  mp_q;
  logic [8:0]  doy_q;
  logic [4:0]  era_q;
  logic [5:0]  cq_q;
  logic [8:0]  yoe_q;
  logic [17:0] doe_q;
  logic signed [23:0] days_q;
  logic signed [SecW-1:0] t_q;
  logic [16:0] tod_q;
  logic [18:0] off_q;
  logic        leap_q;
  logic [4:0]  mlen;
  logic [13:0] yy_c, r400_c;
  logic [28:0] cy_prod, yy_prod;
  logic [8:0]  doy_base;
  logic [1:0]  c100;

  assign yy_c    = (cmo_q <= 7'd2) ? cy_q - 14'd1 : cy_q;
  assign cy_prod = {15'd0, cy_q} * {14'd0, Recip400};
  assign yy_prod = {15'd0, yy_c} * {14'd0, Recip400};
  assign r400_c  = cy_q - {8'd0, cq_q} * 14'd400;

  always_comb begin
    case (cmo_q)
      7'd2:                       mlen = leap_q ? 5'd29 : 5'd28;
      7'd4, 7'd6, 7'd9, 7'd11:    mlen = 5'd30;
      default:                    mlen = 5'd31;
    endcase
  end

  always_comb begin
    case (mp_q)
      4'd1:    doy_base = 9'd31;
      4'd2:    doy_base = 9'd61;
      4'd3:    doy_base = 9'd92;
      4'd4:    doy_base = 9'd122;
      4'd5:    doy_base = 9'd153;
      4'd6:    doy_base = 9'd184;
      4'd7:    doy_base = 9'd214;
      4'd8:    doy_base = 9'd245;
      4'd9:    doy_base = 9'd275;
      4'd10:   doy_base = 9'd306;
      4'd11:   doy_base = 9'd337;
      default: doy_base = 9'd0;
    endcase
  end

  always_comb begin
    if (yoe_q >= 9'd300) begin
      c100 = 2'd3;
    end else if (yoe_q >= 9'd200) begin
      c100 = 2'd2;
    end else if (yoe_q >= 9'd100) begin
      c100 = 2'd1;
    end else begin
      c100 = 2'd0;
    end
  end

  logic held_q;
  assign sts_o.busy  = run_q || held_q;
  assign out_valid_o = held_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      held_q <= 1'b0;
      step_q <= '0;
    end else begin
      if (held_q && !out_stall_i) begin
        held_q <= 1'b0;
      end
      if (cmd_i.convert) begin
        run_q  <= 1'b1;
        step_q <= '0;
      end else if (run_q) begin
        step_q <= step_q + 4'd1;
        if (step_q == 4'd5) begin
          run_q  <= 1'b0;
          held_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.convert) begin
      cy_q <= y_n; cmo_q <= mo_n; cd_q <= d_n; ch_q <= h_n;
      cmi_q <= mi_n; cs_q <= s_n; czh_q <= zh_n; czm_q <= zm_n;
      cbad_q <= bad_n || !cmd_i.phase_ok;
      cneg_q <= zneg_n; ckind_q <= cmd_i.zone_kind;
    end else if (run_q) begin
      case (step_q)
        4'd0: begin
          cq_q   <= cy_prod[28:23];
          era_q  <= yy_prod[27:23];
          yy_q   <= yy_c;
          mp_q   <= (cmo_q > 7'd2) ? 4'(cmo_q - 7'd3) : 4'(cmo_q + 7'd9);
          tod_q  <= 17'({10'd0, ch_q} * 17'd3600 + {10'd0, cmi_q} * 17'd60 + 17'(cs_q));
          off_q  <= 19'({12'd0, czh_q} * 19'd3600 + {12'd0, czm_q} * 19'd60);
        end
        4'd1: begin
          leap_q <= (cy_q[1:0] == 2'd0) && !(r400_c inside {14'd100, 14'd200, 14'd300});
          yoe_q  <= 9'(yy_q - {9'd0, era_q} * 14'd400);
          doy_q  <= 9'(doy_base + {2'd0, cd_q} - 9'd1);
        end
        4'd2: begin
          cok_q <= !cbad_q && (cy_q >= 14'd1) && (cy_q <= 14'd9999) &&
                   (cmo_q >= 7'd1) && (cmo_q <= 7'd12) && (cd_q >= 7'd1) &&
                   ({2'd0, cd_q} <= {4'd0, mlen}) && (ch_q < 7'd24) &&
                   (cmi_q < 7'd60) && (cs_q < 7'd60);
          doe_q <= 18'({9'd0, yoe_q} * 18'd365 + 18'(yoe_q >> 2) -
                       18'(c100) + 18'(doy_q));
        end
        4'd3: begin
          days_q <= $signed(24'({19'd0, era_q} * 24'd146097 + 24'(doe_q))) -
                    24'sd719468;
        end
        4'd4: begin
          t_q <= SecW'(days_q) * 39'sd86400 + $signed(SecW'(tod_q));
        end
        4'd5: begin
          valid_res_o   <= cok_q;
          zone_status_o <= cok_q ? ckind_q : ZoneNone;
          if (!cok_q) begin
            utc_seconds_o <= '0;
          end else if (ckind_q == ZoneApplied) begin
            utc_seconds_o <= cneg_q ? t_q + $signed(SecW'(off_q))
                                    : t_q - $signed(SecW'(off_q));
          end else begin
            utc_seconds_o <= t_q;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
